// ===== sv/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 17;
    localparam int POS_W    = 9;
    localparam int STAT_W   = 3;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;
    localparam int OUT_W    = 120;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 17'd65536;
    localparam logic [SIZE_W-1:0] SIZE_MIN = 17'd1;
    localparam logic [POS_W-1:0]  POS_ALL  = 9'h1FF;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic             pop;
        logic             push;
        logic             init;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] wdata;
    } stk_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
        logic [SIZE_W-1:0] remainder;
    } div_res_t;

endpackage
`default_nettype wire

// ===== sv/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: registers, sequencer, output stage.
// The result turns valid in the same cycle the input turns ready again. An allocate
// runs stack read, index times block size, add of the base and output load; a free
// of a nonzero address runs start, the radix-2 divider that works out offset / block
// size one quotient bit per cycle over 32 steps, the check and output load; a free of
// address zero or an allocate on an empty pool goes straight to output load. One item
// is in work at a time and the input is ready only between items. The result sits in
// an output register, so the next item is taken while a result waits. Any write to
// one of the three registers returns the pool to its reset contents at once: all
// blocks free, counters cleared; no clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_pool_allocator
#(
    parameter int CAPACITY = 256
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,   // free_address
    input  wire logic          s_axis_tuser,   // mode
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // status[2:0], block_address[34:3], in_use_count[43:35], highest_in_use[52:44],
    // total_allocations[84:53], total_frees[116:85], zero fill[119:117]
    output logic [119:0]       m_axis_tdata,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int MAX_COUNT = (CAPACITY < 511) ? CAPACITY : 511;
    localparam int AW        = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam logic [fbpa_pkg::POS_W-1:0] MAX_COUNT_W = fbpa_pkg::POS_W'(MAX_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_FINISH
    } state_t;

    state_t                             state_reg, state_next;
    logic [fbpa_pkg::ADDR_W-1:0]        base_reg, base_next;
    logic [fbpa_pkg::SIZE_W-1:0]        size_reg, size_next;
    logic [fbpa_pkg::POS_W-1:0]         count_reg, count_next;
    logic [fbpa_pkg::POS_W-1:0]         top_reg, top_next;
    logic [fbpa_pkg::POS_W-1:0]         in_use_reg, in_use_next;
    logic [fbpa_pkg::POS_W-1:0]         highest_reg, highest_next;
    logic [fbpa_pkg::ADDR_W-1:0]        alloc_total_reg, alloc_total_next;
    logic [fbpa_pkg::ADDR_W-1:0]        free_total_reg, free_total_next;
    logic [fbpa_pkg::STAT_W-1:0]        status_reg, status_next;
    logic [fbpa_pkg::ADDR_W-1:0]        res_addr_reg, res_addr_next;
    logic [fbpa_pkg::POS_W+fbpa_pkg::SIZE_W-1:0] prod_reg, prod_next;
    logic                               out_valid_reg, out_valid_next;
    logic [fbpa_pkg::OUT_W-1:0]         out_data_reg, out_data_next;

    logic [fbpa_pkg::SIZE_W-1:0]        eff_size;
    logic [fbpa_pkg::POS_W-1:0]         eff_count;
    logic [fbpa_pkg::POS_W-1:0]         new_count;
    logic [fbpa_pkg::POS_W-1:0]         new_eff_count;
    logic [fbpa_pkg::POS_W-1:0]         in_use_inc;
    logic [1:0]                         reg_idx;
    logic                               cfg_wr;
    logic                               cfg_hit;
    logic                               div_start;
    logic [fbpa_pkg::ADDR_W-1:0]        div_dividend;
    fbpa_pkg::div_res_t                 div_res;
    fbpa_pkg::stk_req_t                 stk_req;
    logic [fbpa_pkg::POS_W-1:0]         stk_rdata;

    fbpa_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_size),
        .res      (div_res)
    );

    fbpa_stack
    #(
        .DEPTH (MAX_COUNT),
        .AW    (AW)
    )
    u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stk_req),
        .rdata (stk_rdata)
    );

    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = (reg_idx == fbpa_pkg::REG_BASE) || (reg_idx == fbpa_pkg::REG_SIZE)
                     || (reg_idx == fbpa_pkg::REG_COUNT);
    assign pready  = 1'b1;

    always_comb
    begin
        case (reg_idx)
            fbpa_pkg::REG_BASE:  prdata = base_reg;
            fbpa_pkg::REG_SIZE:  prdata = 32'(size_reg);
            fbpa_pkg::REG_COUNT: prdata = 32'(count_reg);
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = fbpa_pkg::SIZE_MIN;
        end
        else if (size_reg > fbpa_pkg::SIZE_MAX)
        begin
            eff_size = fbpa_pkg::SIZE_MAX;
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_count = fbpa_pkg::POS_W'(1);
        end
        else if (count_reg > MAX_COUNT_W)
        begin
            eff_count = MAX_COUNT_W;
        end
        else
        begin
            eff_count = count_reg;
        end
    end

    always_comb
    begin
        if (new_count == '0)
        begin
            new_eff_count = fbpa_pkg::POS_W'(1);
        end
        else if (new_count > MAX_COUNT_W)
        begin
            new_eff_count = MAX_COUNT_W;
        end
        else
        begin
            new_eff_count = new_count;
        end
    end

    assign in_use_inc    = in_use_reg + 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign div_dividend  = s_axis_tdata - base_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        base_next        = base_reg;
        size_next        = size_reg;
        count_next       = count_reg;
        top_next         = top_reg;
        in_use_next      = in_use_reg;
        highest_next     = highest_reg;
        alloc_total_next = alloc_total_reg;
        free_total_next  = free_total_reg;
        status_next      = status_reg;
        res_addr_next    = res_addr_reg;
        prod_next        = prod_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        new_count        = count_reg;
        div_start        = 1'b0;
        stk_req          = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_addr_next = '0;
                    status_next   = fbpa_pkg::ST_OK;
                    if (s_axis_tuser == fbpa_pkg::MODE_ALLOC)
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = fbpa_pkg::ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            stk_req.pop = 1'b1;
                            stk_req.pos = top_reg - 1'b1;
                            state_next  = S_MUL;
                        end
                    end
                    else if (s_axis_tdata == '0)
                    begin
                        status_next = fbpa_pkg::ST_NULL;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = stk_rdata * eff_size;
                top_next   = top_reg - 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_addr_next    = base_reg + 32'(prod_reg);
                alloc_total_next = alloc_total_reg + 1'b1;
                in_use_next      = in_use_inc;
                if (in_use_inc > highest_reg)
                begin
                    highest_next = in_use_inc;
                end
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if ((div_res.quotient >= 32'(eff_count)) || (div_res.remainder != '0))
                    begin
                        status_next = fbpa_pkg::ST_INVALID;
                    end
                    else if (top_reg >= eff_count)
                    begin
                        status_next = fbpa_pkg::ST_FULL;
                    end
                    else
                    begin
                        stk_req.push    = 1'b1;
                        stk_req.pos     = top_reg;
                        stk_req.wdata   = div_res.quotient[fbpa_pkg::POS_W-1:0];
                        top_next        = top_reg + 1'b1;
                        free_total_next = free_total_reg + 1'b1;
                        if (in_use_reg != '0)
                        begin
                            in_use_next = in_use_reg - 1'b1;
                        end
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, free_total_reg, alloc_total_reg, highest_reg,
                                      in_use_reg, res_addr_reg, status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr && cfg_hit)
        begin
            case (reg_idx)
                fbpa_pkg::REG_BASE:  base_next = pwdata;
                fbpa_pkg::REG_SIZE:  size_next = pwdata[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::REG_COUNT:
                begin
                    count_next = pwdata[fbpa_pkg::POS_W-1:0];
                    new_count  = pwdata[fbpa_pkg::POS_W-1:0];
                end
                default:             base_next = base_reg;
            endcase
            stk_req.init     = 1'b1;
            top_next         = new_eff_count;
            in_use_next      = '0;
            highest_next     = '0;
            alloc_total_next = '0;
            free_total_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            base_reg        <= '0;
            size_reg        <= 17'd16;
            count_reg       <= 9'd256;
            top_reg         <= (MAX_COUNT_W < 9'd256) ? MAX_COUNT_W : 9'd256;
            in_use_reg      <= '0;
            highest_reg     <= '0;
            alloc_total_reg <= '0;
            free_total_reg  <= '0;
            status_reg      <= fbpa_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            base_reg        <= base_next;
            size_reg        <= size_next;
            count_reg       <= count_next;
            top_reg         <= top_next;
            in_use_reg      <= in_use_next;
            highest_reg     <= highest_next;
            alloc_total_reg <= alloc_total_next;
            free_total_reg  <= free_total_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_addr_reg <= res_addr_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

// ===== sv/fbpa_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_divider
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]   dividend,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]   divisor,
    output fbpa_pkg::div_res_t                 res
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [fbpa_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [fbpa_pkg::SIZE_W-1:0]      rem_reg, rem_next;
    logic [fbpa_pkg::ADDR_W-1:0]      quo_reg, quo_next;
    logic [fbpa_pkg::SIZE_W-1:0]      dsr_reg, dsr_next;
    logic [fbpa_pkg::SIZE_W:0]        shifted;
    logic [fbpa_pkg::SIZE_W+1:0]      trial;

    assign shifted = {rem_reg, quo_reg[fbpa_pkg::ADDR_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[fbpa_pkg::SIZE_W+1])
            begin
                rem_next = shifted[fbpa_pkg::SIZE_W-1:0];
            end
            else
            begin
                rem_next = trial[fbpa_pkg::SIZE_W-1:0];
            end
            quo_next = {quo_reg[fbpa_pkg::ADDR_W-2:0], ~trial[fbpa_pkg::SIZE_W+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fbpa_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule
`default_nettype wire

// ===== sv/fbpa_stack.sv =====
// Free index stack: memory plus a low-water mark for never-written entries.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_stack
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fbpa_pkg::stk_req_t            req,
    output logic [fbpa_pkg::POS_W-1:0]         rdata
);

    logic [AW-1:0]                  mem [DEPTH];
    logic [AW-1:0]                  q_reg;
    logic [fbpa_pkg::POS_W-1:0]     pos_reg;
    logic                           fresh_reg;
    logic [fbpa_pkg::POS_W-1:0]     lw_reg, lw_next;
    logic                           fresh;

    assign fresh = req.pos < lw_reg;

    always_comb
    begin
        lw_next = lw_reg;
        if (req.init)
        begin
            lw_next = fbpa_pkg::POS_ALL;
        end
        else if (req.pop && fresh)
        begin
            lw_next = req.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg    <= fbpa_pkg::POS_ALL;
            fresh_reg <= 1'b0;
        end
        else
        begin
            lw_reg <= lw_next;
            if (req.pop)
            begin
                fresh_reg <= fresh;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[req.pos[AW-1:0]] <= req.wdata[AW-1:0];
        end
        if (req.pop)
        begin
            q_reg   <= mem[req.pos[AW-1:0]];
            pos_reg <= req.pos;
        end
    end

    assign rdata = fresh_reg ? pos_reg : fbpa_pkg::POS_W'(q_reg);

endmodule
`default_nettype wire
